// ----- design/hlss_pkg.sv -----
// Shared types and constants for the Heston log-spot stepper.
// Used by hlss_alu, hlss_core and heston_log_spot_step; depends on nothing.
package hlss_pkg;

    typedef struct packed {
        logic [30:0]        time_step;
        logic [30:0]        variance_now;
        logic [30:0]        variance_next;
        logic signed [31:0] normal_draw;
        logic               path_start;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] log_spot_next;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [17:0] correlation;
        logic [30:0]        reversion_level;
        logic [30:0]        reversion_speed;
        logic [30:0]        vol_of_vol;
        logic [16:0]        weight_now;
        logic [16:0]        weight_next;
        logic signed [31:0] drift_rate;
        logic signed [31:0] initial_log_spot;
    } t_cfg;

    typedef enum logic [2:0] {
        REG_CORRELATION,
        REG_REVERSION_LEVEL,
        REG_REVERSION_SPEED,
        REG_VOL_OF_VOL,
        REG_WEIGHT_NOW,
        REG_WEIGHT_NEXT,
        REG_DRIFT_RATE,
        REG_INITIAL_LOG_SPOT
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic flag;
    } t_alu_rsp;

    typedef enum logic [1:0] {
        AS_IDLE,
        AS_RUN,
        AS_FIN
    } t_alu_st;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ISSUE,
        CS_WAIT,
        CS_HOLD
    } t_core_st;

    // one entry per operation of the step, in evaluation order
    typedef enum logic [4:0] {
        ST_R, ST_KR, ST_C, ST_RK, ST_RKT, ST_RKTD, ST_K0, ST_G1, ST_G2,
        ST_G1C, ST_K1, ST_G2C, ST_K2, ST_RR, ST_OM, ST_K3, ST_K4, ST_K3V,
        ST_K4V, ST_ARG, ST_ROOT, ST_X0, ST_MUD, ST_XMU, ST_XK0, ST_K1V,
        ST_XK1, ST_K2V, ST_XK2, ST_RZ, ST_XRZ
    } t_step;

    localparam int unsigned        Q_FRAC = 16;
    localparam logic signed [31:0] Q_ONE  = 32'sd65536;
    localparam logic signed [31:0] Q_HALF = 32'sd32768;

    localparam logic [30:0] RST_SPEED  = 31'd65536;
    localparam logic [30:0] RST_VOL    = 31'd65536;
    localparam logic [16:0] RST_WEIGHT = 17'd32768;

endpackage

// ----- design/heston_log_spot_step.sv -----
// Heston log-spot path stepper (Broadie-Kaya, gamma-weighted), top level.
// Depends on hlss_pkg, hlss_alu and hlss_core.
//
// Input channel (i_in_valid / o_in_stall / i_in) takes one item per path
// step: time step, variance at both ends, normal draw and path-start flag.
// Output channel (o_out_valid / i_out_stall / o_out) returns the new log
// spot and a saturation flag, one item per input item, in order.
// Configuration is a plain write port (i_cfg_we / i_cfg_idx / i_cfg_data);
// the user must write it only while no item is in flight, which the block
// itself does not enforce. One item runs through 31 operations on a single
// shared unit: 17 multiplies (one bit per cycle), one divide, one square
// root and 12 saturating adds; the operand width is never below 32.
// o_in_stall stays high for the whole step. A finished item waits in the
// output register; while the receiver stalls the next item may still be
// accepted, but it cannot complete until the held item is taken.
// Synchronous reset loads the register defaults, clears the stored log
// spot and empties the output register.
module heston_log_spot_step #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  hlss_pkg::t_in_item    i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output hlss_pkg::t_out_item   o_out,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [31:0]           i_cfg_data
);
    import hlss_pkg::*;

    localparam int SW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

    t_cfg      r_cfg;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out;

    logic      busy, done, start, free;
    t_out_item core_item;
    t_alu_req  req;
    t_alu_rsp  rsp;
    logic signed [SW-1:0]         op_a, op_b;
    logic signed [DATA_WIDTH-1:0] res;

    assign start      = i_in_valid & ~busy;
    assign o_in_stall = busy;
    assign free       = ~r_out_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.correlation      <= '0;
            r_cfg.reversion_level  <= '0;
            r_cfg.reversion_speed  <= RST_SPEED;
            r_cfg.vol_of_vol       <= RST_VOL;
            r_cfg.weight_now       <= RST_WEIGHT;
            r_cfg.weight_next      <= RST_WEIGHT;
            r_cfg.drift_rate       <= '0;
            r_cfg.initial_log_spot <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_CORRELATION:      r_cfg.correlation      <= i_cfg_data[17:0];
                REG_REVERSION_LEVEL:  r_cfg.reversion_level  <= i_cfg_data[30:0];
                REG_REVERSION_SPEED:  r_cfg.reversion_speed  <= i_cfg_data[30:0];
                REG_VOL_OF_VOL:       r_cfg.vol_of_vol       <= i_cfg_data[30:0];
                REG_WEIGHT_NOW:       r_cfg.weight_now       <= i_cfg_data[16:0];
                REG_WEIGHT_NEXT:      r_cfg.weight_next      <= i_cfg_data[16:0];
                REG_DRIFT_RATE:       r_cfg.drift_rate       <= i_cfg_data;
                REG_INITIAL_LOG_SPOT: r_cfg.initial_log_spot <= i_cfg_data;
                default:              r_cfg.drift_rate       <= r_cfg.drift_rate;
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (done) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= core_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    hlss_core #(
        .DW (DATA_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_in),
        .i_cfg   (r_cfg),
        .i_free  (free),
        .o_busy  (busy),
        .o_done  (done),
        .o_item  (core_item),
        .o_req   (req),
        .o_a     (op_a),
        .o_b     (op_b),
        .i_rsp   (rsp),
        .i_res   (res)
    );

    hlss_alu #(
        .DW (DATA_WIDTH)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_rsp   (rsp),
        .o_res   (res)
    );

endmodule

// ----- design/hlss_alu.sv -----
// Shared iterative arithmetic unit: saturating add/sub, shift-add
// multiply, restoring divide and digit-by-digit square root.
// Depends on hlss_pkg.
module hlss_alu #(
    parameter int DW = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  hlss_pkg::t_alu_req                       i_req,
    input  logic signed [((DW > 32) ? DW : 32)-1:0]  i_a,
    input  logic signed [((DW > 32) ? DW : 32)-1:0]  i_b,
    output hlss_pkg::t_alu_rsp                       o_rsp,
    output logic signed [DW-1:0]                     o_res
);
    import hlss_pkg::*;

    localparam int SW = (DW > 32) ? DW : 32;
    localparam int LW = SW + Q_FRAC;
    localparam int SQ = (LW + 1) / 2;
    localparam int XW = 2 * SW - Q_FRAC;
    localparam int CW = $clog2(LW);

    localparam logic signed [SW:0] DMAX = {{(SW-DW+2){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [SW:0] DMIN = ~DMAX;
    localparam logic [XW-1:0]      LIM  = {{(XW-DW+1){1'b0}}, {(DW-1){1'b1}}};

    t_alu_st             r_st, n_st;
    t_alu_op             r_op, n_op;
    logic                r_neg, n_neg;
    logic [SW-1:0]       r_ma, n_ma;
    logic [SW-1:0]       r_md, n_md;
    logic [SW:0]         r_hi, n_hi;
    logic [LW-1:0]       r_lo, n_lo;
    logic [2*SQ-1:0]     r_sr, n_sr;
    logic [SQ+1:0]       r_srem, n_srem;
    logic [SQ-1:0]       r_root, n_root;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_zero, n_zero;
    logic                r_flag, n_flag;
    logic                r_done, n_done;
    logic signed [DW-1:0] r_res, n_res;

    logic [SW-1:0]        mag_a, mag_b;
    logic signed [SW:0]   sa, sb, ssum;
    logic signed [DW-1:0] add_res;
    logic                 add_flag;
    logic [CW-1:0]        last;
    logic [SW:0]          msum, remsh;
    logic                 dge, sge;
    logic [SQ+1:0]        rsh, trial;
    logic [XW-1:0]        fin_mag, fin_lim, fin_val;
    logic [DW-1:0]        fin_low;
    logic                 fin_flag;

    assign mag_a = i_a[SW-1] ? unsigned'(-i_a) : unsigned'(i_a);
    assign mag_b = i_b[SW-1] ? unsigned'(-i_b) : unsigned'(i_b);

    always_comb begin
        sa   = {i_a[SW-1], i_a};
        sb   = {i_b[SW-1], i_b};
        ssum = (i_req.op == ALU_SUB) ? sa - sb : sa + sb;
        add_flag = 1'b0;
        if (ssum > DMAX) begin
            add_res  = DMAX[DW-1:0];
            add_flag = 1'b1;
        end else if (ssum < DMIN) begin
            add_res  = DMIN[DW-1:0];
            add_flag = 1'b1;
        end else begin
            add_res = ssum[DW-1:0];
        end
    end

    // one iteration step of each algorithm
    always_comb begin
        msum  = r_hi + (r_lo[0] ? {1'b0, r_ma} : '0);
        remsh = {r_hi[SW-1:0], r_lo[LW-1]};
        dge   = (remsh >= {1'b0, r_md});
        rsh   = {r_srem[SQ-1:0], r_sr[2*SQ-1 -: 2]};
        trial = {r_root, 2'b01};
        sge   = (rsh >= trial);
    end

    always_comb begin
        case (r_op)
            ALU_MUL:  last = CW'(SW - 1);
            ALU_DIV:  last = CW'(LW - 1);
            ALU_SQRT: last = CW'(SQ - 1);
            default:  last = '0;
        endcase
    end

    // magnitude to signed result with clamp to the data range
    always_comb begin
        case (r_op)
            ALU_MUL:  fin_mag = XW'({r_hi[SW-1:0], r_lo[SW-1:0]} >> Q_FRAC);
            ALU_DIV:  fin_mag = r_zero ? '0 : XW'(r_lo);
            ALU_SQRT: fin_mag = XW'(r_root);
            default:  fin_mag = '0;
        endcase
        fin_lim  = r_neg ? LIM + XW'(1) : LIM;
        fin_flag = (fin_mag > fin_lim);
        fin_val  = fin_flag ? fin_lim : fin_mag;
        fin_low  = fin_val[DW-1:0];
    end

    always_comb begin
        n_st   = r_st;
        n_op   = r_op;
        n_neg  = r_neg;
        n_ma   = r_ma;
        n_md   = r_md;
        n_hi   = r_hi;
        n_lo   = r_lo;
        n_sr   = r_sr;
        n_srem = r_srem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_zero = r_zero;
        n_flag = r_flag;
        n_res  = r_res;
        n_done = 1'b0;
        case (r_st)
            AS_IDLE: begin
                if (i_req.start) begin
                    n_op   = i_req.op;
                    n_cnt  = '0;
                    n_hi   = '0;
                    n_srem = '0;
                    n_root = '0;
                    n_flag = 1'b0;
                    n_neg  = i_a[SW-1] ^ i_b[SW-1];
                    n_ma   = mag_a;
                    n_md   = mag_b;
                    n_zero = (mag_a == '0);
                    case (i_req.op)
                        ALU_ADD, ALU_SUB: begin
                            n_res  = add_res;
                            n_flag = add_flag;
                            n_done = 1'b1;
                        end
                        ALU_MUL: begin
                            n_lo = LW'(mag_b);
                            n_st = AS_RUN;
                        end
                        ALU_DIV: begin
                            n_lo = {mag_a, {Q_FRAC{1'b0}}};
                            n_st = AS_RUN;
                        end
                        ALU_SQRT: begin
                            // clamp a negative argument to zero
                            n_neg  = 1'b0;
                            n_flag = i_a[SW-1];
                            n_sr   = i_a[SW-1] ? '0 : (2*SQ)'({mag_a, {Q_FRAC{1'b0}}});
                            n_st   = AS_RUN;
                        end
                        default: begin
                            n_res  = '0;
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            AS_RUN: begin
                n_cnt = r_cnt + CW'(1);
                case (r_op)
                    ALU_MUL: begin
                        n_hi = {1'b0, msum[SW:1]};
                        n_lo = LW'({msum[0], r_lo[SW-1:1]});
                    end
                    ALU_DIV: begin
                        n_hi = dge ? remsh - {1'b0, r_md} : remsh;
                        n_lo = {r_lo[LW-2:0], dge};
                    end
                    ALU_SQRT: begin
                        n_srem = sge ? rsh - trial : rsh;
                        n_root = {r_root[SQ-2:0], sge};
                        n_sr   = r_sr << 2;
                    end
                    default: n_st = AS_FIN;
                endcase
                if (r_cnt == last) begin
                    n_st = AS_FIN;
                end
            end
            AS_FIN: begin
                n_res  = signed'(r_neg ? (~fin_low + 1'b1) : fin_low);
                n_flag = r_flag | fin_flag;
                n_done = 1'b1;
                n_st   = AS_IDLE;
            end
            default: n_st = AS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= AS_IDLE;
            r_done <= 1'b0;
            r_flag <= 1'b0;
            r_op   <= ALU_ADD;
            r_cnt  <= '0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
            r_flag <= n_flag;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_ma   <= n_ma;
        r_md   <= n_md;
        r_hi   <= n_hi;
        r_lo   <= n_lo;
        r_sr   <= n_sr;
        r_srem <= n_srem;
        r_root <= n_root;
        r_zero <= n_zero;
        r_res  <= n_res;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.flag = r_flag;
    assign o_res      = r_res;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (r_st == AS_IDLE))
        else $error("alu start while busy");

    a_fin_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == AS_FIN) |=> r_done)
        else $error("alu finish without done");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("alu done longer than one cycle");

endmodule

// ----- design/hlss_core.sv -----
// Step sequencer: walks the operation list of one path step through the
// shared unit, keeps the intermediates and the stored log spot.
// Depends on hlss_pkg.
module hlss_core #(
    parameter int DW = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    input  hlss_pkg::t_in_item                       i_item,
    input  hlss_pkg::t_cfg                           i_cfg,
    input  logic                                     i_free,
    output logic                                     o_busy,
    output logic                                     o_done,
    output hlss_pkg::t_out_item                      o_item,
    output hlss_pkg::t_alu_req                       o_req,
    output logic signed [((DW > 32) ? DW : 32)-1:0]  o_a,
    output logic signed [((DW > 32) ? DW : 32)-1:0]  o_b,
    input  hlss_pkg::t_alu_rsp                       i_rsp,
    input  logic signed [DW-1:0]                     i_res
);
    import hlss_pkg::*;

    localparam int SW = (DW > 32) ? DW : 32;
    localparam logic signed [SW-1:0] X_MAX = SW'(32'sh7fffffff);
    localparam logic signed [SW-1:0] X_MIN = SW'(32'sh80000000);

    t_core_st r_st, n_st;
    t_step    r_step;
    t_in_item r_item;
    logic     r_flag;
    logic signed [31:0]   r_log_spot;
    logic signed [DW-1:0] r_r, r_c, r_t, r_u, r_k0, r_g1, r_g2, r_k1, r_k2;
    logic signed [DW-1:0] r_om, r_k3, r_k4, r_root, r_x;

    logic signed [SW-1:0] e_rho, e_theta, e_kappa, e_eps, e_g1w, e_g2w, e_mu, e_init;
    logic signed [SW-1:0] e_dt, e_v0, e_v1, e_z, e_half, e_one, e_spot;
    logic signed [SW-1:0] xs, xc;
    logic                 clip;
    t_alu_op              alu_op;

    assign e_rho   = SW'(i_cfg.correlation);
    assign e_theta = SW'(i_cfg.reversion_level);
    assign e_kappa = SW'(i_cfg.reversion_speed);
    assign e_eps   = SW'(i_cfg.vol_of_vol);
    assign e_g1w   = SW'(i_cfg.weight_now);
    assign e_g2w   = SW'(i_cfg.weight_next);
    assign e_mu    = SW'(i_cfg.drift_rate);
    assign e_init  = SW'(i_cfg.initial_log_spot);
    assign e_dt    = SW'(r_item.time_step);
    assign e_v0    = SW'(r_item.variance_now);
    assign e_v1    = SW'(r_item.variance_next);
    assign e_z     = SW'(r_item.normal_draw);
    assign e_half  = SW'(Q_HALF);
    assign e_one   = SW'(Q_ONE);
    assign e_spot  = r_item.path_start ? e_init : SW'(r_log_spot);

    // operation and operands of the current step
    always_comb begin
        alu_op = ALU_ADD;
        o_a    = '0;
        o_b    = '0;
        case (r_step)
            ST_R:    begin alu_op = ALU_DIV;  o_a = e_rho;        o_b = e_eps;        end
            ST_KR:   begin alu_op = ALU_MUL;  o_a = e_kappa;      o_b = SW'(r_r);     end
            ST_C:    begin alu_op = ALU_SUB;  o_a = SW'(r_t);     o_b = e_half;       end
            ST_RK:   begin alu_op = ALU_MUL;  o_a = SW'(r_r);     o_b = e_kappa;      end
            ST_RKT:  begin alu_op = ALU_MUL;  o_a = SW'(r_t);     o_b = e_theta;      end
            ST_RKTD: begin alu_op = ALU_MUL;  o_a = SW'(r_t);     o_b = e_dt;         end
            ST_K0:   begin alu_op = ALU_SUB;  o_a = '0;           o_b = SW'(r_t);     end
            ST_G1:   begin alu_op = ALU_MUL;  o_a = e_g1w;        o_b = e_dt;         end
            ST_G2:   begin alu_op = ALU_MUL;  o_a = e_g2w;        o_b = e_dt;         end
            ST_G1C:  begin alu_op = ALU_MUL;  o_a = SW'(r_g1);    o_b = SW'(r_c);     end
            ST_K1:   begin alu_op = ALU_SUB;  o_a = SW'(r_t);     o_b = SW'(r_r);     end
            ST_G2C:  begin alu_op = ALU_MUL;  o_a = SW'(r_g2);    o_b = SW'(r_c);     end
            ST_K2:   begin alu_op = ALU_ADD;  o_a = SW'(r_t);     o_b = SW'(r_r);     end
            ST_RR:   begin alu_op = ALU_MUL;  o_a = e_rho;        o_b = e_rho;        end
            ST_OM:   begin alu_op = ALU_SUB;  o_a = e_one;        o_b = SW'(r_t);     end
            ST_K3:   begin alu_op = ALU_MUL;  o_a = SW'(r_g1);    o_b = SW'(r_om);    end
            ST_K4:   begin alu_op = ALU_MUL;  o_a = SW'(r_g2);    o_b = SW'(r_om);    end
            ST_K3V:  begin alu_op = ALU_MUL;  o_a = SW'(r_k3);    o_b = e_v0;         end
            ST_K4V:  begin alu_op = ALU_MUL;  o_a = SW'(r_k4);    o_b = e_v1;         end
            ST_ARG:  begin alu_op = ALU_ADD;  o_a = SW'(r_t);     o_b = SW'(r_u);     end
            ST_ROOT: begin alu_op = ALU_SQRT; o_a = SW'(r_t);     o_b = '0;           end
            ST_X0:   begin alu_op = ALU_ADD;  o_a = e_spot;       o_b = '0;           end
            ST_MUD:  begin alu_op = ALU_MUL;  o_a = e_mu;         o_b = e_dt;         end
            ST_XMU:  begin alu_op = ALU_ADD;  o_a = SW'(r_x);     o_b = SW'(r_t);     end
            ST_XK0:  begin alu_op = ALU_ADD;  o_a = SW'(r_x);     o_b = SW'(r_k0);    end
            ST_K1V:  begin alu_op = ALU_MUL;  o_a = SW'(r_k1);    o_b = e_v0;         end
            ST_XK1:  begin alu_op = ALU_ADD;  o_a = SW'(r_x);     o_b = SW'(r_t);     end
            ST_K2V:  begin alu_op = ALU_MUL;  o_a = SW'(r_k2);    o_b = e_v1;         end
            ST_XK2:  begin alu_op = ALU_ADD;  o_a = SW'(r_x);     o_b = SW'(r_t);     end
            ST_RZ:   begin alu_op = ALU_MUL;  o_a = SW'(r_root);  o_b = e_z;          end
            ST_XRZ:  begin alu_op = ALU_ADD;  o_a = SW'(r_x);     o_b = SW'(r_t);     end
            default: begin alu_op = ALU_ADD;  o_a = '0;           o_b = '0;           end
        endcase
    end

    // clamp the final log spot to 32 bits
    always_comb begin
        xs   = SW'(r_x);
        clip = 1'b0;
        xc   = xs;
        if (xs > X_MAX) begin
            xc   = X_MAX;
            clip = 1'b1;
        end else if (xs < X_MIN) begin
            xc   = X_MIN;
            clip = 1'b1;
        end
    end

    always_comb begin
        n_st        = r_st;
        o_req.start = 1'b0;
        o_req.op    = alu_op;
        o_done      = 1'b0;
        case (r_st)
            CS_IDLE:  if (i_start) n_st = CS_ISSUE;
            CS_ISSUE: begin
                o_req.start = 1'b1;
                n_st        = CS_WAIT;
            end
            CS_WAIT: begin
                if (i_rsp.done) begin
                    n_st = (r_step == ST_XRZ) ? CS_HOLD : CS_ISSUE;
                end
            end
            CS_HOLD: begin
                // hold until the output register can take the item
                if (i_free) begin
                    o_done = 1'b1;
                    n_st   = CS_IDLE;
                end
            end
            default: n_st = CS_IDLE;
        endcase
    end

    assign o_busy               = (r_st != CS_IDLE);
    assign o_item.log_spot_next = xc[31:0];
    assign o_item.saturated     = r_flag | clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= CS_IDLE;
            r_step     <= ST_R;
            r_flag     <= 1'b0;
            r_log_spot <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == CS_IDLE && i_start) begin
                r_step <= ST_R;
                r_flag <= 1'b0;
            end else if (r_st == CS_WAIT && i_rsp.done) begin
                r_flag <= r_flag | i_rsp.flag;
                if (r_step != ST_XRZ) begin
                    r_step <= t_step'(r_step + 5'd1);
                end
            end
            if (o_done) begin
                r_log_spot <= xc[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == CS_IDLE && i_start) begin
            r_item <= i_item;
        end
        if (r_st == CS_WAIT && i_rsp.done) begin
            case (r_step)
                ST_R:    r_r    <= i_res;
                ST_C:    r_c    <= i_res;
                ST_K0:   r_k0   <= i_res;
                ST_G1:   r_g1   <= i_res;
                ST_G2:   r_g2   <= i_res;
                ST_K1:   r_k1   <= i_res;
                ST_K2:   r_k2   <= i_res;
                ST_OM:   r_om   <= i_res;
                ST_K3:   r_k3   <= i_res;
                ST_K4:   r_k4   <= i_res;
                ST_K4V:  r_u    <= i_res;
                ST_ROOT: r_root <= i_res;
                ST_X0, ST_XMU, ST_XK0, ST_XK1, ST_XK2, ST_XRZ: r_x <= i_res;
                default: r_t    <= i_res;
            endcase
        end
    end

endmodule

// ----- bench/tb.sv -----
// Testbench for heston_log_spot_step: directed table, extremes, random steps,
// each result checked against a fixed-point predictor of the log-spot update.
// Depends on hlss_pkg and the heston_log_spot_step RTL.
`timescale 1ns / 100ps

module tb;
    import hlss_pkg::*;

    localparam int          DW        = 32;
    localparam int          N_RAND    = 1450;
    localparam int          WD_LIMIT  = 40000;
    localparam int          TAIL      = 800;
    localparam longint      DW_MAX    = 64'sd2147483647;
    localparam longint      DW_MIN    = -64'sd2147483648;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_item;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [31:0] cfg_data = '0;

    heston_log_spot_step #(.DATA_WIDTH(DW)) u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out(out_item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // predictor copy of registers and state
    longint m_rho, m_theta, m_kappa, m_eps, m_g1, m_g2, m_mu, m_x0, m_spot;
    bit     m_flag;

    t_out_item spot_queue[$];
    int        n_err = 0;
    int        n_done = 0;
    int        n_sat = 0;
    int        idle_cycles = 0;
    bit        stim_done = 1'b0;

    task automatic report(input string what, input longint got, input longint exp_v);
        $display("mismatch #%0d %s: got %0d expected %0d", n_err + 1, what, got, exp_v);
        n_err++;
    endtask

    function automatic longint clamp_dw(input longint v);
        if (v > DW_MAX) begin
            m_flag = 1'b1;
            return DW_MAX;
        end
        if (v < DW_MIN) begin
            m_flag = 1'b1;
            return DW_MIN;
        end
        return v;
    endfunction

    // operands are at most 33 bits wide, so 64-bit add never overflows
    function automatic longint sat_add(input longint a, input longint b);
        return clamp_dw(a + b);
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        logic [127:0] p;
        logic [127:0] ma, mb;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = (ma * mb) >> 16;
        if (neg) begin
            if (p > 128'd2147483648) begin
                m_flag = 1'b1;
                return DW_MIN;
            end
            return -longint'(p);
        end
        if (p > 128'd2147483647) begin
            m_flag = 1'b1;
            return DW_MAX;
        end
        return longint'(p);
    endfunction

    function automatic longint qdiv(input longint a, input longint d);
        logic [127:0] q, ma, md;
        bit           neg;
        neg = (a < 0) != (d < 0);
        ma = (a < 0) ? -a : a;
        md = (d < 0) ? -d : d;
        if (md == 0) begin
            if (ma == 0) return 0;
            m_flag = 1'b1;
            return neg ? DW_MIN : DW_MAX;
        end
        q = (ma << 16) / md;
        if (neg) begin
            if (q > 128'd2147483648) begin
                m_flag = 1'b1;
                return DW_MIN;
            end
            return -longint'(q);
        end
        if (q > 128'd2147483647) begin
            m_flag = 1'b1;
            return DW_MAX;
        end
        return longint'(q);
    endfunction

    function automatic longint qsqrt(input longint x);
        logic [63:0] t, lo, hi, mid;
        t = 64'(x) << 16;
        lo = 0;
        hi = 64'd1 << 24;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (mid * mid <= t) lo = mid;
            else hi = mid - 1;
        end
        return longint'(lo);
    endfunction

    function automatic t_out_item predict_spot(input t_in_item it);
        longint    dt, v0, v1, z, r, c, k0, k1, k2, k3, k4, om, g1dt, g2dt, arg, root, x;
        t_out_item res;
        dt = it.time_step;
        v0 = it.variance_now;
        v1 = it.variance_next;
        z = it.normal_draw;
        m_flag = 1'b0;
        r = qdiv(m_rho, m_eps);
        c = sat_add(qmul(m_kappa, r), -32768);
        k0 = sat_add(0, -qmul(qmul(qmul(r, m_kappa), m_theta), dt));
        g1dt = qmul(m_g1, dt);
        g2dt = qmul(m_g2, dt);
        k1 = sat_add(qmul(g1dt, c), -r);
        k2 = sat_add(qmul(g2dt, c), r);
        om = sat_add(65536, -qmul(m_rho, m_rho));
        k3 = qmul(g1dt, om);
        k4 = qmul(g2dt, om);
        arg = sat_add(qmul(k3, v0), qmul(k4, v1));
        if (arg < 0) begin
            m_flag = 1'b1;
            arg = 0;
        end
        root = qsqrt(arg);
        x = it.path_start ? m_x0 : m_spot;
        x = sat_add(x, qmul(m_mu, dt));
        x = sat_add(x, k0);
        x = sat_add(x, qmul(k1, v0));
        x = sat_add(x, qmul(k2, v1));
        x = sat_add(x, qmul(root, z));
        m_spot = x;
        res.log_spot_next = x[31:0];
        res.saturated = m_flag;
        return res;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        case (idx)
            REG_CORRELATION:      m_rho = longint'(signed'(val[17:0]));
            REG_REVERSION_LEVEL:  m_theta = val[30:0];
            REG_REVERSION_SPEED:  m_kappa = val[30:0];
            REG_VOL_OF_VOL:       m_eps = val[30:0];
            REG_WEIGHT_NOW:       m_g1 = val[16:0];
            REG_WEIGHT_NEXT:      m_g2 = val[16:0];
            REG_DRIFT_RATE:       m_mu = longint'(signed'(val));
            REG_INITIAL_LOG_SPOT: m_x0 = longint'(signed'(val));
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // drop valid, then wait until every result is taken
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (spot_queue.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // present one item; expected either typed in or from the predictor
    task automatic send_step(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item pred;
        int        gap;
        gap = $urandom_range(0, 18);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        pred = predict_spot(it);
        if (typed && pred != want)
            report("directed row vs predictor", pred.log_spot_next, want.log_spot_next);
        spot_queue.insert(spot_queue.size(), typed ? want : pred);
        @(posedge clk);
        while (in_stall) @(posedge clk);
        // leave valid to the next item or to the drain
        @(negedge clk);
    endtask

    function automatic t_in_item mk(input longint dt, input longint v0, input longint v1,
                                    input longint z, input bit ps);
        t_in_item it;
        it.time_step = dt[30:0];
        it.variance_now = v0[30:0];
        it.variance_next = v1[30:0];
        it.normal_draw = z[31:0];
        it.path_start = ps;
        return it;
    endfunction

    function automatic longint pick31();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 31'h7fffffff;
            2: return $urandom_range(0, 65536 * 4);
            3: return $urandom_range(0, 65536 / 8);
            default: return $urandom & 32'h7fffffff;
        endcase
    endfunction

    function automatic longint pick_z();
        case ($urandom_range(0, 4))
            0: return 32'sh7fffffff;
            1: return -64'sd2147483648;
            2: return longint'($urandom_range(0, 6 * 65536)) - 3 * 65536;
            default: return longint'(signed'($urandom));
        endcase
    endfunction

    // receiver: draw a stall per item, check on acceptance
    initial begin
        t_out_item exp_item;
        int        hold;
        hold = 0;
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                out_stall <= 1'b1;
                hold--;
            end else begin
                out_stall <= 1'b0;
            end
            @(posedge clk);
            if (out_valid && !out_stall) begin
                n_done++;
                if (spot_queue.size() == 0) begin
                    report("unexpected result", out_item.log_spot_next, 0);
                end else begin
                    exp_item = spot_queue.pop_front();
                    if (out_item.log_spot_next !== exp_item.log_spot_next)
                        report("log_spot_next", out_item.log_spot_next,
                               exp_item.log_spot_next);
                    if (out_item.saturated !== exp_item.saturated)
                        report("saturated", out_item.saturated, exp_item.saturated);
                    if (exp_item.saturated) n_sat++;
                end
                hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("watchdog: no progress, %0d results left", spot_queue.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    typedef struct {
        longint dt, v0, v1, z;
        bit     ps;
        bit     typed;
        longint want;
        bit     want_sat;
    } t_row;

    initial begin
        t_row       rows[$];
        t_out_item  w;
        int         i;
        int         phase;
        m_rho = 0; m_theta = 0; m_kappa = 65536; m_eps = 65536;
        m_g1 = 32768; m_g2 = 32768; m_mu = 0; m_x0 = 0; m_spot = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: defaults after reset, zero step keeps log spot at zero
        rows.insert(rows.size(), t_row'{0, 0, 0, 0, 0, 1, 0, 0});
        rows.insert(rows.size(),
                    t_row'{0, 31'h7fffffff, 31'h7fffffff, 32'sh7fffffff, 1, 1, 0, 0});
        rows.insert(rows.size(), t_row'{65536, 65536, 65536, 65536, 0, 0, 0, 0});
        rows.insert(rows.size(), t_row'{31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
                                        32'sh7fffffff, 0, 0, 0, 0});
        rows.insert(rows.size(), t_row'{31'h7fffffff, 0, 31'h7fffffff,
                                        -64'sd2147483648, 0, 0, 0, 0});
        rows.insert(rows.size(), t_row'{65536, 0, 0, 0, 1, 0, 0, 0});
        foreach (rows[k]) begin
            w.log_spot_next = rows[k].want[31:0];
            w.saturated = rows[k].want_sat;
            send_step(mk(rows[k].dt, rows[k].v0, rows[k].v1, rows[k].z, rows[k].ps),
                      rows[k].typed, w);
        end
        wait_drain();

        // extremes: rho = +1, tiny eps (quotient saturates), big drift
        write_reg(REG_CORRELATION, 32'h10000);
        write_reg(REG_VOL_OF_VOL, 32'd1);
        write_reg(REG_REVERSION_LEVEL, 32'h7fffffff);
        write_reg(REG_REVERSION_SPEED, 32'h7fffffff);
        write_reg(REG_WEIGHT_NOW, 32'h10000);
        write_reg(REG_WEIGHT_NEXT, 32'h0);
        write_reg(REG_DRIFT_RATE, 32'h7fffffff);
        write_reg(REG_INITIAL_LOG_SPOT, 32'h80000000);
        send_step(mk(65536, 65536, 65536, 65536, 1), 0, w);
        send_step(mk(31'h7fffffff, 31'h7fffffff, 0, -64'sd2147483648, 0), 0, w);
        send_step(mk(0, 0, 0, 0, 0), 0, w);
        wait_drain();
        // rho = -1, drift most negative
        write_reg(REG_CORRELATION, 32'h30000);
        write_reg(REG_DRIFT_RATE, 32'h80000000);
        send_step(mk(65536, 65536, 31'h7fffffff, 32'sh7fffffff, 0), 0, w);
        send_step(mk(31'h7fffffff, 0, 0, 0, 1), 0, w);
        wait_drain();

        // random phases, each with its own register setting
        for (phase = 0; phase < 10; phase++) begin
            if (phase == 9) begin
                write_reg(REG_CORRELATION, 32'h10000);
                write_reg(REG_VOL_OF_VOL, 32'h7fffffff);
                write_reg(REG_WEIGHT_NOW, 32'h10000);
                write_reg(REG_WEIGHT_NEXT, 32'h10000);
            end else begin
                write_reg(REG_CORRELATION, $urandom_range(0, 131072) - 65536);
                write_reg(REG_REVERSION_LEVEL, $urandom_range(0, 3) == 0 ?
                          ($urandom & 32'h7fffffff) : $urandom_range(0, 65536));
                write_reg(REG_REVERSION_SPEED, $urandom_range(0, 3) == 0 ?
                          ($urandom & 32'h7fffffff) : $urandom_range(0, 5 * 65536));
                write_reg(REG_VOL_OF_VOL, $urandom_range(0, 3) == 0 ?
                          ($urandom & 32'h7fffffff) : $urandom_range(1, 2 * 65536));
                write_reg(REG_WEIGHT_NOW, $urandom_range(0, 65536));
                write_reg(REG_WEIGHT_NEXT, $urandom_range(0, 65536));
                write_reg(REG_DRIFT_RATE, $urandom_range(0, 3) == 0 ?
                          $urandom : $urandom_range(0, 65536) - 32768);
                write_reg(REG_INITIAL_LOG_SPOT, $urandom);
            end
            for (i = 0; i < N_RAND / 10; i++) begin
                // mostly short paths with small steps, occasional extremes
                if ($urandom_range(0, 4) != 0)
                    send_step(mk($urandom_range(0, 65536 / 4), $urandom_range(0, 65536),
                                 $urandom_range(0, 65536), pick_z(),
                                 $urandom_range(0, 15) == 0), 0, w);
                else
                    send_step(mk(pick31(), pick31(), pick31(), pick_z(),
                                 $urandom_range(0, 1)), 0, w);
            end
            wait_drain();
        end

        stim_done = 1'b1;
        i = 0;
        while (spot_queue.size() != 0 && i < 20 * WD_LIMIT) begin
            @(posedge clk);
            i++;
        end
        repeat (TAIL) @(posedge clk);
        $display("covered %0d results over 13 register settings, %0d with saturation",
                 n_done, n_sat);
        if (spot_queue.size() != 0)
            report("results never arrived", spot_queue.size(), 0);
        if (n_err == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
